@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define AMI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion lbl failed");
// Clocked check that also holds during reset.
`define AMI_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion lbl failed");
`else
`define AMI_ASSERT(lbl, clk, rst, prop)
`define AMI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/ami_pkg.sv @@
// Package with widths, lane codes and beat types of the affine inverse block.
package ami_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   // Full products of two coefficients.
   localparam int PROD_BITS  = 2 * WORD_BITS;
   // Signed determinant and its magnitude.
   localparam int DET_S_BITS = PROD_BITS + 1;
   localparam int DET_BITS   = PROD_BITS;
   // Signed numerators and their magnitudes share one width.
   localparam int NUM_BITS   = 2 * WORD_BITS + 2 * FRAC_BITS + 1;
   localparam int LANES      = 6;
   // Divider stages: overflow stage, one stage per quotient bit, final stage.
   localparam int DIV_LAT    = WORD_BITS + 2;

   // Lane codes, one per inverse coefficient.
   localparam int LANE_A = 0;
   localparam int LANE_B = 1;
   localparam int LANE_C = 2;
   localparam int LANE_D = 3;
   localparam int LANE_E = 4;
   localparam int LANE_F = 5;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_a;
      logic signed [WORD_BITS-1:0] coef_b;
      logic signed [WORD_BITS-1:0] coef_c;
      logic signed [WORD_BITS-1:0] coef_d;
      logic signed [WORD_BITS-1:0] coef_e;
      logic signed [WORD_BITS-1:0] coef_f;
   } ami_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] inv_a;
      logic signed [WORD_BITS-1:0] inv_b;
      logic signed [WORD_BITS-1:0] inv_c;
      logic signed [WORD_BITS-1:0] inv_d;
      logic signed [WORD_BITS-1:0] inv_e;
      logic signed [WORD_BITS-1:0] inv_f;
      logic                        singular;
      logic                        saturated;
   } ami_rsp_type;

   // One division job: magnitudes and the sign of the quotient.
   typedef struct packed {
      logic [NUM_BITS-1:0] num_mag;
      logic [DET_BITS-1:0] det_mag;
      logic                neg_q;
   } ami_lane_type;

   // Control that rides alongside the divider stages.
   typedef struct packed {
      logic valid;
      logic singular;
   } ami_tag_type;

endpackage

@@ design/affine_matrix_inverse.sv @@
// Top level of the 2D affine transform inverse.
// Takes one matrix [a b c; d e f] of signed Q16.16 coefficients per beat and
// returns its inverse, truncated toward zero and clamped to Q16.16, with
// singular and saturated flags. A new beat is taken every cycle unless a shown
// result is stalled. Each result passes 38 register stages. The stages are
// three front stages for the products, the determinant and the magnitudes, 34
// stages of the six parallel bit-per-stage dividers, and one output register.
// A stall on the result side while a result is shown freezes the whole
// pipeline, so nothing is lost or repeated.
`include "assert_macros.svh"

module affine_matrix_inverse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ami_pkg::ami_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ami_pkg::ami_rsp_type rsp_data
);
   import ami_pkg::*;

   logic                     advance;
   logic                     front_valid;
   logic                     front_singular;
   ami_lane_type [LANES-1:0] front_lanes;

   logic signed [WORD_BITS-1:0] quo [LANES];
   logic [LANES-1:0]            sat;

   ami_tag_type tag_ff [DIV_LAT];
   logic        rsp_valid_ff;
   ami_rsp_type rsp_data_ff;
   ami_tag_type tail;

   // The pipeline moves unless a finished beat waits at a stalled output.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   ami_front u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .in_valid     (req_valid),
      .in_data      (req_data),
      .out_valid    (front_valid),
      .out_singular (front_singular),
      .out_lanes    (front_lanes)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      ami_div u_div (
         .clock   (clock),
         .enable  (advance),
         .in_lane (front_lanes[i]),
         .out_quo (quo[i]),
         .out_sat (sat[i])
      );
   end

   // Valid and singular ride beside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (advance) begin
         tag_ff[0] <= '{valid: front_valid, singular: front_singular};
         for (int i = 1; i < DIV_LAT; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign tail = tag_ff[DIV_LAT-1];

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.inv_a     <= tail.singular ? '0 : quo[LANE_A];
         rsp_data_ff.inv_b     <= tail.singular ? '0 : quo[LANE_B];
         rsp_data_ff.inv_c     <= tail.singular ? '0 : quo[LANE_C];
         rsp_data_ff.inv_d     <= tail.singular ? '0 : quo[LANE_D];
         rsp_data_ff.inv_e     <= tail.singular ? '0 : quo[LANE_E];
         rsp_data_ff.inv_f     <= tail.singular ? '0 : quo[LANE_F];
         rsp_data_ff.singular  <= tail.singular;
         rsp_data_ff.saturated <= !tail.singular && (|sat);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A singular result carries zero coefficients (checked for a, c and e) and no saturation.
   `AMI_ASSERT(a_singular_zero, clock, reset, rsp_valid_ff && rsp_data_ff.singular |-> rsp_data_ff.inv_a == '0 && rsp_data_ff.inv_e == '0 && rsp_data_ff.inv_c == '0 && !rsp_data_ff.saturated)
   // A stalled output freezes the beat at the end of the divider.
   `AMI_ASSERT(a_tail_frozen, clock, reset, rsp_valid_ff && rsp_stall |=> $stable(tail))
   // After reset no result beat is shown.
   `AMI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid_ff)

endmodule

@@ design/ami_front.sv @@
// Front end: products, determinant, numerators and their magnitudes.
module ami_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     enable,
   input  logic                                     in_valid,
   input  ami_pkg::ami_req_type                     in_data,
   output logic                                     out_valid,
   output logic                                     out_singular,
   output ami_pkg::ami_lane_type [ami_pkg::LANES-1:0] out_lanes
);
   import ami_pkg::*;

   logic [2:0] valid_ff;

   logic signed [PROD_BITS-1:0] p_ae_ff, p_bd_ff, p_bf_ff, p_ce_ff, p_af_ff, p_cd_ff;
   logic signed [WORD_BITS-1:0] a_ff, b_ff, d_ff, e_ff;

   logic signed [DET_S_BITS-1:0] det_ff;
   logic signed [NUM_BITS-1:0]   num_ff [LANES];

   ami_lane_type [LANES-1:0] lane_ff;
   logic                     singular_ff;

   // Valid bits advance with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Stage one: the six full products.
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ae_ff <= PROD_BITS'(in_data.coef_a) * PROD_BITS'(in_data.coef_e);
         p_bd_ff <= PROD_BITS'(in_data.coef_b) * PROD_BITS'(in_data.coef_d);
         p_bf_ff <= PROD_BITS'(in_data.coef_b) * PROD_BITS'(in_data.coef_f);
         p_ce_ff <= PROD_BITS'(in_data.coef_c) * PROD_BITS'(in_data.coef_e);
         p_af_ff <= PROD_BITS'(in_data.coef_a) * PROD_BITS'(in_data.coef_f);
         p_cd_ff <= PROD_BITS'(in_data.coef_c) * PROD_BITS'(in_data.coef_d);
         a_ff    <= in_data.coef_a;
         b_ff    <= in_data.coef_b;
         d_ff    <= in_data.coef_d;
         e_ff    <= in_data.coef_e;
      end
   end

   // Stage two: determinant and the six signed numerators.
   always_ff @(posedge clock) begin
      if (enable) begin
         det_ff         <= DET_S_BITS'(p_ae_ff) - DET_S_BITS'(p_bd_ff);
         num_ff[LANE_A] <= NUM_BITS'(e_ff) <<< (2 * FRAC_BITS);
         num_ff[LANE_B] <= -(NUM_BITS'(b_ff) <<< (2 * FRAC_BITS));
         num_ff[LANE_C] <= (NUM_BITS'(p_bf_ff) - NUM_BITS'(p_ce_ff)) <<< FRAC_BITS;
         num_ff[LANE_D] <= -(NUM_BITS'(d_ff) <<< (2 * FRAC_BITS));
         num_ff[LANE_E] <= NUM_BITS'(a_ff) <<< (2 * FRAC_BITS);
         num_ff[LANE_F] <= -((NUM_BITS'(p_af_ff) - NUM_BITS'(p_cd_ff)) <<< FRAC_BITS);
      end
   end

   // Stage three: magnitudes, quotient signs and the singular test.
   always_ff @(posedge clock) begin
      if (enable) begin
         singular_ff <= (det_ff == '0);
         for (int i = 0; i < LANES; i++) begin
            lane_ff[i].num_mag <= num_ff[i][NUM_BITS-1] ? NUM_BITS'(-num_ff[i])
                                                        : NUM_BITS'(num_ff[i]);
            lane_ff[i].det_mag <= det_ff[DET_S_BITS-1] ? DET_BITS'(-det_ff)
                                                       : DET_BITS'(det_ff);
            lane_ff[i].neg_q   <= num_ff[i][NUM_BITS-1] ^ det_ff[DET_S_BITS-1];
         end
      end
   end

   assign out_valid    = valid_ff[2];
   assign out_singular = singular_ff;
   assign out_lanes    = lane_ff;

endmodule

@@ design/ami_div.sv @@
// Pipelined restoring divider with truncation and saturation for one lane.
module ami_div (
   input  logic                                   clock,
   input  logic                                   enable,
   input  ami_pkg::ami_lane_type                  in_lane,
   output logic signed [ami_pkg::WORD_BITS-1:0]   out_quo,
   output logic                                   out_sat
);
   import ami_pkg::*;

   logic [DET_BITS-1:0]  rem_ff [WORD_BITS+1];
   logic [DET_BITS-1:0]  det_ff [WORD_BITS+1];
   logic [WORD_BITS-1:0] low_ff [WORD_BITS+1];
   logic [WORD_BITS-1:0] quo_ff [WORD_BITS+1];
   logic                 neg_ff [WORD_BITS+1];
   logic                 ovf_ff [WORD_BITS+1];

   logic [NUM_BITS-1:0]  num_hi;
   logic [WORD_BITS-1:0] lim;
   logic                 sat;
   logic signed [WORD_BITS-1:0] quo_ff_out;
   logic                 sat_ff_out;

   // A quotient of 2^WORD_BITS or more shows in the upper numerator bits.
   assign num_hi = in_lane.num_mag >> WORD_BITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         ovf_ff[0] <= (num_hi >= NUM_BITS'(in_lane.det_mag));
         rem_ff[0] <= num_hi[DET_BITS-1:0];
         det_ff[0] <= in_lane.det_mag;
         low_ff[0] <= in_lane.num_mag[WORD_BITS-1:0];
         quo_ff[0] <= '0;
         neg_ff[0] <= in_lane.neg_q;
      end
   end

   // One quotient bit per stage.
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
      logic [DET_BITS:0] rem_sh;
      logic [DET_BITS:0] diff;
      logic              ge;

      assign rem_sh = {rem_ff[k], low_ff[k][WORD_BITS-1]};
      assign diff   = rem_sh - {1'b0, det_ff[k]};
      assign ge     = (rem_sh >= {1'b0, det_ff[k]});

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge ? diff[DET_BITS-1:0] : rem_sh[DET_BITS-1:0];
            quo_ff[k+1] <= {quo_ff[k][WORD_BITS-2:0], ge};
            low_ff[k+1] <= {low_ff[k][WORD_BITS-2:0], 1'b0};
            det_ff[k+1] <= det_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // Range limit depends on the sign of the quotient.
   assign lim = neg_ff[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
   assign sat = ovf_ff[WORD_BITS] || (quo_ff[WORD_BITS] > lim);

   // Final stage: clamp or apply the sign.
   always_ff @(posedge clock) begin
      if (enable) begin
         sat_ff_out <= sat;
         if (sat) begin
            quo_ff_out <= lim;
         end else if (neg_ff[WORD_BITS]) begin
            quo_ff_out <= -quo_ff[WORD_BITS];
         end else begin
            quo_ff_out <= quo_ff[WORD_BITS];
         end
      end
   end

   assign out_quo = quo_ff_out;
   assign out_sat = sat_ff_out;

endmodule

@@ tb/affine_matrix_inverse_tb.sv @@
// Self-checking testbench for the affine 2x3 matrix inverse block.
`timescale 1ns / 1ps

module affine_matrix_inverse_tb;
   import ami_pkg::*;

   localparam int RANDOM_BEATS = 1400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [WORD_BITS-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [WORD_BITS-1:0] WMAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_BITS-1:0] WMIN = 32'sh8000_0000;

   typedef struct {
      ami_req_type matrix;
      logic        typed;
      ami_rsp_type inverse;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ami_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ami_rsp_type rsp_data;

   ami_rsp_type  pending_inverses[$];
   stim_row_type directed_rows[$];
   int           error_count;
   int           idle_cycles;
   logic         hold_request;

   affine_matrix_inverse uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Exact inverse, truncated toward zero and clamped to the word range.
   function automatic ami_rsp_type invert_matrix(ami_req_type m);
      logic signed [127:0] a, b, c, d, e, f, det, q;
      logic signed [127:0] num [LANES];
      logic signed [127:0] hi_lim, lo_lim;
      ami_rsp_type r;
      logic signed [WORD_BITS-1:0] lane [LANES];
      a = 128'(m.coef_a); b = 128'(m.coef_b); c = 128'(m.coef_c);
      d = 128'(m.coef_d); e = 128'(m.coef_e); f = 128'(m.coef_f);
      hi_lim = 128'(WMAX);
      lo_lim = 128'(WMIN);
      r = '0;
      det = a * e - b * d;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      num[LANE_A] = e <<< (2 * FRAC_BITS);
      num[LANE_B] = -(b <<< (2 * FRAC_BITS));
      num[LANE_C] = (b * f - c * e) <<< FRAC_BITS;
      num[LANE_D] = -(d <<< (2 * FRAC_BITS));
      num[LANE_E] = a <<< (2 * FRAC_BITS);
      num[LANE_F] = -((a * f - c * d) <<< FRAC_BITS);
      for (int k = 0; k < LANES; k++) begin
         q = num[k] / det;
         if (q > hi_lim) begin
            lane[k] = WMAX;
            r.saturated = 1'b1;
         end else if (q < lo_lim) begin
            lane[k] = WMIN;
            r.saturated = 1'b1;
         end else begin
            lane[k] = q[WORD_BITS-1:0];
         end
      end
      r.inv_a = lane[LANE_A]; r.inv_b = lane[LANE_B]; r.inv_c = lane[LANE_C];
      r.inv_d = lane[LANE_D]; r.inv_e = lane[LANE_E]; r.inv_f = lane[LANE_F];
      return r;
   endfunction

   function automatic ami_req_type make_matrix(
      logic signed [WORD_BITS-1:0] a, b, c, d, e, f);
      ami_req_type m;
      m.coef_a = a; m.coef_b = b; m.coef_c = c;
      m.coef_d = d; m.coef_e = e; m.coef_f = f;
      return m;
   endfunction

   function automatic ami_rsp_type make_inverse(
      logic signed [WORD_BITS-1:0] a, b, c, d, e, f, logic sing, logic sat);
      ami_rsp_type r;
      r.inv_a = a; r.inv_b = b; r.inv_c = c;
      r.inv_d = d; r.inv_e = e; r.inv_f = f;
      r.singular = sing; r.saturated = sat;
      return r;
   endfunction

   // Coefficient within a few units of zero, so that most inverses stay in range.
   function automatic logic signed [WORD_BITS-1:0] near_unit();
      return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
   endfunction

   function automatic logic signed [WORD_BITS-1:0] any_word();
      return $urandom();
   endfunction

   // Random matrix: mostly well-scaled, some singular, some tiny, some full-range words.
   function automatic ami_req_type random_matrix();
      ami_req_type m;
      int          pick;
      pick = $urandom_range(0, 99);
      m = make_matrix(near_unit(), near_unit(), any_word(),
                      near_unit(), near_unit(), any_word());
      if (pick < 10) begin
         // Linear part of the second row copies the first: determinant is zero.
         m.coef_d = m.coef_a;
         m.coef_e = m.coef_b;
      end else if (pick < 35) begin
         m = make_matrix(any_word(), any_word(), any_word(),
                         any_word(), any_word(), any_word());
      end else if (pick < 45) begin
         // Tiny a and e coefficients, from -8 to 8 in the last place.
         m.coef_a = $signed($urandom_range(0, 16)) - 8;
         m.coef_e = $signed($urandom_range(0, 16)) - 8;
      end
      return m;
   endfunction

   task automatic check_word(string name, logic [WORD_BITS-1:0] exp_v,
                             logic [WORD_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // One beat offered at the falling edge and held until it is taken.
   task automatic send_beat(ami_req_type m, ami_rsp_type inverse);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = m;
      do @(posedge clock); while (req_stall);
      pending_inverses.push_back(inverse);
   endtask

   // Random gap after a beat: mostly none or short, now and then long.
   task automatic sender_gap();
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      n = (pick < 55) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Result side: random stalls, stretches with none, one long hold-off on request.
   initial begin
      int pick;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               rsp_stall = 1'b0;
               repeat ($urandom_range(0, 30)) @(negedge clock);
            end else if (pick < 95) begin
               rsp_stall = 1'b1;
               repeat ($urandom_range(0, 3)) @(negedge clock);
            end else begin
               rsp_stall = 1'b1;
               repeat ($urandom_range(10, 50)) @(negedge clock);
            end
         end
      end
   end

   // Result checking and the idle watchdog.
   always @(posedge clock) begin
      ami_rsp_type exp_r;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("affine_matrix_inverse_tb: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_inverses.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_data);
               error_count++;
            end else begin
               exp_r = pending_inverses.pop_front();
               check_word("inv_a", exp_r.inv_a, rsp_data.inv_a);
               check_word("inv_b", exp_r.inv_b, rsp_data.inv_b);
               check_word("inv_c", exp_r.inv_c, rsp_data.inv_c);
               check_word("inv_d", exp_r.inv_d, rsp_data.inv_d);
               check_word("inv_e", exp_r.inv_e, rsp_data.inv_e);
               check_word("inv_f", exp_r.inv_f, rsp_data.inv_f);
               check_word("singular", WORD_BITS'(exp_r.singular),
                          WORD_BITS'(rsp_data.singular));
               check_word("saturated", WORD_BITS'(exp_r.saturated),
                          WORD_BITS'(rsp_data.saturated));
            end
         end
      end
   end

   // Stimulus: directed table first, then random matrices.
   initial begin
      stim_row_type row;
      ami_req_type  m;
      error_count  = 0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;

      // Rows with an expected inverse that can be read off directly.
      directed_rows.push_back('{make_matrix(0, 0, 0, 0, 0, 0), 1'b1,
                                make_inverse(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      directed_rows.push_back('{make_matrix(ONE, 0, 0, 0, ONE, 0), 1'b1,
                                make_inverse(ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b0)});
      directed_rows.push_back('{make_matrix(ONE, 0, 2 * ONE, 0, ONE, -3 * ONE), 1'b1,
                                make_inverse(ONE, 0, -2 * ONE, 0, ONE, 3 * ONE, 1'b0, 1'b0)});
      directed_rows.push_back('{make_matrix(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 1'b1,
                                make_inverse(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      directed_rows.push_back('{make_matrix(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN), 1'b1,
                                make_inverse(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
      directed_rows.push_back('{make_matrix(1, 0, 0, 0, 1, 0), 1'b1,
                                make_inverse(WMAX, 0, 0, 0, WMAX, 0, 1'b0, 1'b1)});
      directed_rows.push_back('{make_matrix(1, 0, 0, 0, -1, 0), 1'b1,
                                make_inverse(WMAX, 0, 0, 0, WMIN, 0, 1'b0, 1'b1)});
      // Rows checked against the predictor.
      directed_rows.push_back('{make_matrix(WMIN, 0, WMAX, 0, WMIN, WMIN), 1'b0, '0});
      directed_rows.push_back('{make_matrix(WMAX, WMIN, WMIN, WMAX, WMAX, WMAX), 1'b0, '0});
      directed_rows.push_back('{make_matrix(0, ONE, 5 * ONE, -ONE, 0, 7 * ONE), 1'b0, '0});
      directed_rows.push_back('{make_matrix(2 * ONE, ONE, -1, ONE, 3 * ONE, 1), 1'b0, '0});
      directed_rows.push_back('{make_matrix(-1, -1, -1, -1, 1, -1), 1'b0, '0});
      directed_rows.push_back('{make_matrix(3, 7, WMAX, 2, 5, WMIN), 1'b0, '0});
      directed_rows.push_back('{make_matrix(WMAX, 0, 0, 0, 1, 0), 1'b0, '0});
      directed_rows.push_back('{make_matrix(-32'sh5555_5555, 32'sh5555_5555,
                                            -32'sh5555_5555, 32'sh2AAA_AAAA,
                                            -32'sh2AAA_AAAA, 32'sh2AAA_AAAA), 1'b0, '0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.matrix, row.typed ? row.inverse : invert_matrix(row.matrix));
         sender_gap();
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // Midway, the result side holds off while beats keep coming.
         if (n == RANDOM_BEATS / 2) hold_request = 1'b1;
         m = random_matrix();
         send_beat(m, invert_matrix(m));
         if (!hold_request) sender_gap();
      end
      @(negedge clock);
      req_valid = 1'b0;

      wait (pending_inverses.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("affine_matrix_inverse_tb: clean");
      end else begin
         $display("affine_matrix_inverse_tb: errors");
      end
      $finish;
   end

endmodule
